// ===== sv/onr_pkg.sv =====
// Shared widths, constants and register codes for the Oren-Nayar diffuse factor block.
// Used by the channel interfaces, the root and divider pipelines and the top level.
package onr_pkg;

  localparam int IN_W      = 16;
  localparam int IN_FRAC   = 14;
  localparam int OUT_FRAC  = 16;
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam int FACTOR_W  = 25;
  localparam int TERM_SH   = GAIN_FRAC + IN_FRAC - OUT_FRAC;

  // Cosine cutoff: ceil(0.9999 * 2^IN_FRAC)
  localparam logic signed [IN_W-1:0] COS_LIMIT =
    IN_W'(((9999 << IN_FRAC) + 9999) / 10000);

  localparam logic [GAIN_W-1:0] GAIN_A_RST = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_B_RST = '0;

  // Square root pipeline: operand, root and partial remainder widths
  localparam int SQ_IN_W  = 34;
  localparam int SQ_OUT_W = 17;
  localparam int SQ_REM_W = 20;

  // Divider pipeline: dividend, divisor and quotient widths
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 34;
  localparam int DIV_Q_W = 29;

  // Sideband carried alongside the root and divider pipelines
  localparam int TAG_W = 40;

  typedef enum logic [0:0] {
    REG_GAIN_A = 1'b0,
    REG_GAIN_B = 1'b1
  } cfg_reg_e;

endpackage

// ===== sv/onr_if.sv =====
// Valid/ready channel interfaces for shading samples and diffuse factors.
// Depends on onr_pkg for field widths.
interface onr_in_if;
  logic valid;
  logic ready;
  logic signed [onr_pkg::IN_W-1:0] incident_x;
  logic signed [onr_pkg::IN_W-1:0] incident_y;
  logic signed [onr_pkg::IN_W-1:0] incident_z;
  logic signed [onr_pkg::IN_W-1:0] outgoing_x;
  logic signed [onr_pkg::IN_W-1:0] outgoing_y;
  logic signed [onr_pkg::IN_W-1:0] outgoing_z;
  logic signed [onr_pkg::IN_W-1:0] normal_x;
  logic signed [onr_pkg::IN_W-1:0] normal_y;
  logic signed [onr_pkg::IN_W-1:0] normal_z;

  modport source (output valid, incident_x, incident_y, incident_z, outgoing_x, outgoing_y,
                  outgoing_z, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, incident_x, incident_y, incident_z, outgoing_x, outgoing_y,
                outgoing_z, normal_x, normal_y, normal_z, output ready);
endinterface

interface onr_out_if;
  logic valid;
  logic ready;
  logic signed [onr_pkg::FACTOR_W-1:0] factor;
  logic saturated;

  modport source (output valid, factor, saturated, input ready);
  modport sink (input valid, factor, saturated, output ready);
endinterface

// ===== sv/onr_sqrt.sv =====
// Pipelined integer floor square root, one root bit per stage, with sideband tag.
// Depends on onr_pkg for widths.
module onr_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [onr_pkg::SQ_IN_W-1:0]  op_i,
  input  logic [onr_pkg::TAG_W-1:0]    tag_i,
  output logic                         valid_o,
  output logic [onr_pkg::SQ_OUT_W-1:0] root_o,
  output logic [onr_pkg::TAG_W-1:0]    tag_o
);

  localparam int N  = onr_pkg::SQ_OUT_W;
  localparam int RW = onr_pkg::SQ_REM_W;

  logic [N-1:0]                vld_q;
  logic [onr_pkg::SQ_IN_W-1:0] op_q   [N];
  logic [RW-1:0]               rem_q  [N];
  logic [N-1:0]                root_q [N];
  logic [onr_pkg::TAG_W-1:0]   tag_q  [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                        vld_p;
    logic [onr_pkg::SQ_IN_W-1:0] op_p;
    logic [RW-1:0]               rem_p;
    logic [N-1:0]                root_p;
    logic [onr_pkg::TAG_W-1:0]   tag_p;
    logic [RW+1:0]               rem_sh;
    logic [RW+1:0]               trial;
    logic [RW-1:0]               rem_d;
    logic [N-1:0]                root_d;

    if (s == 0) begin : g_first
      assign vld_p  = valid_i;
      assign op_p   = op_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = tag_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign op_p   = op_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign tag_p  = tag_q[s-1];
    end

    always_comb begin
      rem_sh = {rem_p, op_p[2*(N-1-s)+1 -: 2]};
      trial  = (RW+2)'({root_p, 2'b01});
      if (rem_sh >= trial) begin
        rem_d  = RW'(rem_sh - trial);
        root_d = {root_p[N-2:0], 1'b1};
      end else begin
        rem_d  = RW'(rem_sh);
        root_d = {root_p[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        op_q[s]   <= op_p;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        tag_q[s]  <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign tag_o   = tag_q[N-1];

endmodule

// ===== sv/onr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband tag.
// Expects dividend < divisor * 2^DIV_Q_W. Depends on onr_pkg for widths.
module onr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [onr_pkg::DIV_N_W-1:0] num_i,
  input  logic [onr_pkg::DIV_D_W-1:0] den_i,
  input  logic [onr_pkg::TAG_W-1:0]   tag_i,
  output logic                        valid_o,
  output logic [onr_pkg::DIV_Q_W-1:0] quot_o,
  output logic [onr_pkg::TAG_W-1:0]   tag_o
);

  localparam int QW = onr_pkg::DIV_Q_W;
  localparam int NW = onr_pkg::DIV_N_W;
  localparam int DW = onr_pkg::DIV_D_W;
  localparam int CW = DW + QW;

  logic [QW-1:0]             vld_q;
  logic [NW-1:0]             rem_q [QW];
  logic [DW-1:0]             den_q [QW];
  logic [QW-1:0]             quo_q [QW];
  logic [onr_pkg::TAG_W-1:0] tag_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic                      vld_p;
    logic [NW-1:0]             rem_p;
    logic [DW-1:0]             den_p;
    logic [QW-1:0]             quo_p;
    logic [onr_pkg::TAG_W-1:0] tag_p;
    logic [CW-1:0]             rem_x;
    logic [CW-1:0]             den_sh;
    logic [NW-1:0]             rem_d;
    logic [QW-1:0]             quo_d;

    if (j == 0) begin : g_first
      assign vld_p = valid_i;
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
      assign tag_p = tag_i;
    end else begin : g_next
      assign vld_p = vld_q[j-1];
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
      assign tag_p = tag_q[j-1];
    end

    always_comb begin
      rem_x  = CW'(rem_p);
      den_sh = CW'(den_p) << (QW - 1 - j);
      if (rem_x >= den_sh) begin
        rem_d = NW'(rem_x - den_sh);
        quo_d = {quo_p[QW-2:0], 1'b1};
      end else begin
        rem_d = rem_p;
        quo_d = {quo_p[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_p;
        quo_q[j] <= quo_d;
        tag_q[j] <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== sv/oren_nayar_diffuse_factor.sv =====
// Pipeline: 6 front stages, 17-stage square root, 2 stages, 29-stage divider,
// 3 product stages and an output register.
// Throughput: one sample per cycle; the whole pipeline advances together and holds
// while a result waits at the output. Reset clears all valid bits, gain_a to 1.0
// and gain_b to 0. Depends on onr_pkg, onr_if, onr_sqrt and onr_div.
module oren_nayar_diffuse_factor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  onr_in_if.sink                     in_i,
  onr_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [onr_pkg::GAIN_W-1:0] cfg_data_i
);

  localparam int F = onr_pkg::IN_FRAC;

  // Clamp a dot product to [-1,1] and round half away from zero to F bits
  function automatic logic signed [15:0] cos_round(logic signed [33:0] d);
    logic [28:0] mag;
    logic [15:0] r;
    if (d >= 34'sd268435456 || d <= -34'sd268435456) begin
      mag = 29'h1000_0000;
    end else if (d < 0) begin
      mag = 29'(-d);
    end else begin
      mag = 29'(d);
    end
    r = 16'((30'(mag) + (30'd1 << (F - 1))) >> F);
    return (d < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [17:0] rnd_f(logic signed [31:0] x);
    logic [31:0] mag;
    logic [17:0] r;
    mag = (x < 0) ? 32'(-x) : 32'(x);
    r = 18'((mag + (32'd1 << (F - 1))) >> F);
    return (x < 0) ? -$signed(r) : $signed(r);
  endfunction

  logic en;
  logic out_valid_q;
  logic signed [onr_pkg::FACTOR_W-1:0] factor_q;
  logic sat_q;
  logic [onr_pkg::GAIN_W-1:0] gain_a_q, gain_b_q;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = out_valid_q;
  assign out_o.factor    = factor_q;
  assign out_o.saturated = sat_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_a_q <= onr_pkg::GAIN_A_RST;
      gain_b_q <= onr_pkg::GAIN_B_RST;
    end else if (cfg_we_i) begin
      case (onr_pkg::cfg_reg_e'(cfg_idx_i))
        onr_pkg::REG_GAIN_A: gain_a_q <= cfg_data_i;
        onr_pkg::REG_GAIN_B: gain_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: dot product terms
  logic signed [15:0] wi_in [3], wo_in [3], nn_in [3];
  logic signed [31:0] pi_d [3], po_d [3];
  logic signed [15:0] wi1_q [3], wo1_q [3], nn1_q [3];
  logic signed [31:0] pi1_q [3], po1_q [3];
  logic v1_q;

  assign wi_in[0] = in_i.incident_x;
  assign wi_in[1] = in_i.incident_y;
  assign wi_in[2] = in_i.incident_z;
  assign wo_in[0] = in_i.outgoing_x;
  assign wo_in[1] = in_i.outgoing_y;
  assign wo_in[2] = in_i.outgoing_z;
  assign nn_in[0] = in_i.normal_x;
  assign nn_in[1] = in_i.normal_y;
  assign nn_in[2] = in_i.normal_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pi_d[k] = wi_in[k] * nn_in[k];
      po_d[k] = wo_in[k] * nn_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wi1_q <= wi_in;
      wo1_q <= wo_in;
      nn1_q <= nn_in;
      pi1_q <= pi_d;
      po1_q <= po_d;
    end
  end

  // Stage 2: cosines
  logic signed [15:0] ci2_q, co2_q;
  logic signed [15:0] wi2_q [3], wo2_q [3], nn2_q [3];
  logic v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ci2_q <= cos_round(34'(pi1_q[0]) + 34'(pi1_q[1]) + 34'(pi1_q[2]));
      co2_q <= cos_round(34'(po1_q[0]) + 34'(po1_q[1]) + 34'(po1_q[2]));
      wi2_q <= wi1_q;
      wo2_q <= wo1_q;
      nn2_q <= nn1_q;
    end
  end

  // Stage 3: normal scaled by cosine, squared cosines
  logic signed [15:0] cs2, cb2;
  logic signed [31:0] cs_sq, cb_sq;
  logic signed [31:0] pri_d [3], pro_d [3];
  logic signed [31:0] pri3_q [3], pro3_q [3];
  logic [28:0] cs3_q, cb3sq_q;
  logic signed [15:0] cb3_q;
  logic gate3_q;
  logic signed [15:0] wi3_q [3], wo3_q [3];
  logic v3_q;

  always_comb begin
    cs2 = (ci2_q < co2_q) ? ci2_q : co2_q;
    cb2 = (ci2_q < co2_q) ? co2_q : ci2_q;
    cs_sq = cs2 * cs2;
    cb_sq = cb2 * cb2;
    for (int k = 0; k < 3; k++) begin
      pri_d[k] = nn2_q[k] * ci2_q;
      pro_d[k] = nn2_q[k] * co2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pri3_q  <= pri_d;
      pro3_q  <= pro_d;
      cs3_q   <= 29'(cs_sq);
      cb3sq_q <= 29'(cb_sq);
      cb3_q   <= cb2;
      gate3_q <= (ci2_q < onr_pkg::COS_LIMIT) && (co2_q < onr_pkg::COS_LIMIT);
      wi3_q   <= wi2_q;
      wo3_q   <= wo2_q;
    end
  end

  // Stage 4: tangent projections, root operands for the sines
  logic signed [17:0] a4_q [3], b4_q [3];
  logic [28:0] sa4_q, sb4_q;
  logic signed [15:0] cb4_q;
  logic gate4_q;
  logic v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a4_q[k] <= 18'(wi3_q[k]) - rnd_f(pri3_q[k]);
        b4_q[k] <= 18'(wo3_q[k]) - rnd_f(pro3_q[k]);
      end
      sa4_q   <= 29'h1000_0000 - cs3_q;
      sb4_q   <= 29'h1000_0000 - cb3sq_q;
      cb4_q   <= cb3_q;
      gate4_q <= gate3_q;
    end
  end

  // Stage 5: squares and cross products
  logic signed [35:0] sqa_d [3], sqb_d [3], pab_d [3];
  logic [32:0] sqa5_q [3], sqb5_q [3];
  logic signed [35:0] pab5_q [3];
  logic [28:0] sa5_q, sb5_q;
  logic signed [15:0] cb5_q;
  logic gate5_q;
  logic v5_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sqa_d[k] = a4_q[k] * a4_q[k];
      sqb_d[k] = b4_q[k] * b4_q[k];
      pab_d[k] = a4_q[k] * b4_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sqa5_q[k] <= 33'(sqa_d[k]);
        sqb5_q[k] <= 33'(sqb_d[k]);
      end
      pab5_q  <= pab_d;
      sa5_q   <= sa4_q;
      sb5_q   <= sb4_q;
      cb5_q   <= cb4_q;
      gate5_q <= gate4_q;
    end
  end

  // Stage 6: squared lengths and projection dot product
  logic [33:0] n1_6_q, n2_6_q;
  logic signed [35:0] p6_q;
  logic [28:0] sa6_q, sb6_q;
  logic signed [15:0] cb6_q;
  logic gate6_q;
  logic v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_6_q  <= 34'(sqa5_q[0]) + 34'(sqa5_q[1]) + 34'(sqa5_q[2]);
      n2_6_q  <= 34'(sqb5_q[0]) + 34'(sqb5_q[1]) + 34'(sqb5_q[2]);
      p6_q    <= pab5_q[0] + pab5_q[1] + pab5_q[2];
      sa6_q   <= sa5_q;
      sb6_q   <= sb5_q;
      cb6_q   <= cb5_q;
      gate6_q <= gate5_q;
    end
  end

  // Square roots: two lengths and two sines in parallel
  logic sq_valid;
  logic [onr_pkg::SQ_OUT_W-1:0] l1, l2, sin_a, sin_b;
  logic [onr_pkg::TAG_W-1:0] tag_n1, tag_sa;

  onr_sqrt u_sqrt_l1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .op_i(n1_6_q),
    .tag_i({3'b000, gate6_q, p6_q}), .valid_o(sq_valid), .root_o(l1), .tag_o(tag_n1)
  );
  onr_sqrt u_sqrt_l2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .op_i(n2_6_q),
    .tag_i('0), .valid_o(), .root_o(l2), .tag_o()
  );
  onr_sqrt u_sqrt_sa (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .op_i(34'(sa6_q)),
    .tag_i({24'h0, cb6_q}), .valid_o(), .root_o(sin_a), .tag_o(tag_sa)
  );
  onr_sqrt u_sqrt_sb (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .op_i(34'(sb6_q)),
    .tag_i('0), .valid_o(), .root_o(sin_b), .tag_o()
  );

  // Stage 7: length product
  logic [33:0] ll_prod;
  logic [33:0] dd7_q;
  logic signed [35:0] p7_q;
  logic gate7_q;
  logic [onr_pkg::SQ_OUT_W-1:0] sina7_q, sinb7_q;
  logic signed [15:0] cb7_q;
  logic v7_q;

  assign ll_prod = l1 * l2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd7_q   <= ll_prod;
      p7_q    <= $signed(tag_n1[35:0]);
      gate7_q <= tag_n1[36];
      sina7_q <= sin_a;
      sinb7_q <= sin_b;
      cb7_q   <= $signed(tag_sa[15:0]);
    end
  end

  // Stage 8: divider operands; clamp case detected up front
  logic mc_ok, mc_ovf;
  logic [47:0] mnum;
  logic [15:0] cb_abs;
  logic [47:0] mn8_q, tn8_q;
  logic [33:0] md8_q, td8_q;
  logic [onr_pkg::TAG_W-1:0] mtag8_q, ttag8_q;
  logic v8_q;

  always_comb begin
    mc_ok  = gate7_q && (p7_q > 0) && (dd7_q != '0);
    mnum   = {p7_q[33:0], 14'h0};
    mc_ovf = {1'b0, mnum} >= {dd7_q, 15'h0};
    cb_abs = (cb7_q < 0) ? 16'(-cb7_q) : 16'(cb7_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mc_ok && !mc_ovf) begin
        mn8_q <= mnum;
        md8_q <= dd7_q;
      end else begin
        mn8_q <= '0;
        md8_q <= 34'd1;
      end
      mtag8_q <= {21'h0, mc_ovf, mc_ok, sina7_q};
      tn8_q   <= 48'({sinb7_q, 14'h0});
      td8_q   <= (cb7_q == 0) ? 34'd1 : 34'(cb_abs);
      ttag8_q <= {39'h0, cb7_q < 0};
    end
  end

  // Dividers: projection cosine and tangent
  logic dv_valid;
  logic [onr_pkg::DIV_Q_W-1:0] mq, tq;
  logic [onr_pkg::TAG_W-1:0] mtag, ttag;

  onr_div u_div_mc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .num_i(mn8_q), .den_i(md8_q),
    .tag_i(mtag8_q), .valid_o(dv_valid), .quot_o(mq), .tag_o(mtag)
  );
  onr_div u_div_tan (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .num_i(tn8_q), .den_i(td8_q),
    .tag_i(ttag8_q), .valid_o(), .quot_o(tq), .tag_o(ttag)
  );

  // Stage 9: maxcos * sin(alpha)
  logic [14:0] maxcos;
  logic [31:0] t1_prod;
  logic [14:0] t1_9_q;
  logic [28:0] tan9_q;
  logic neg9_q;
  logic v9_q;

  always_comb begin
    if (!mtag[17]) begin
      maxcos = '0;
    end else if (mtag[18] || mq > 29'd16384) begin
      maxcos = 15'd16384;
    end else begin
      maxcos = mq[14:0];
    end
    t1_prod = maxcos * mtag[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_9_q <= t1_prod[F +: 15];
      tan9_q <= tq;
      neg9_q <= ttag[0];
    end
  end

  // Stage 10: times |tan(beta)|
  logic [43:0] t2_prod;
  logic [29:0] t2_10_q;
  logic neg10_q;
  logic v10_q;

  assign t2_prod = t1_9_q * tan9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_10_q <= t2_prod[F +: 30];
      neg10_q <= neg9_q;
    end
  end

  // Stage 11: B term
  logic [46:0] b_prod;
  logic [32:0] term11_q;
  logic neg11_q;
  logic v11_q;

  assign b_prod = gain_b_q * t2_10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      term11_q <= b_prod[onr_pkg::TERM_SH +: 33];
      neg11_q  <= neg10_q;
    end
  end

  // Output register: A +/- B term, clipped
  logic signed [34:0] sum;
  logic signed [34:0] a_ext, t_ext;

  always_comb begin
    a_ext = $signed({18'h0, gain_a_q});
    t_ext = $signed({2'b00, term11_q});
    sum   = neg11_q ? (a_ext - t_ext) : (a_ext + t_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sum > 35'sd16777215) begin
        factor_q <= 25'sh0FF_FFFF;
        sat_q    <= 1'b1;
      end else if (sum < -35'sd16777216) begin
        factor_q <= 25'sh100_0000;
        sat_q    <= 1'b1;
      end else begin
        factor_q <= 25'(sum);
        sat_q    <= 1'b0;
      end
    end
  end

  // Valid bits advance with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      v9_q        <= 1'b0;
      v10_q       <= 1'b0;
      v11_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= sq_valid;
      v8_q        <= v7_q;
      v9_q        <= dv_valid;
      v10_q       <= v9_q;
      v11_q       <= v10_q;
      out_valid_q <= v11_q;
    end
  end

endmodule
